FILE: rtl/ghm_pkg.sv
`default_nettype none
package ghm_pkg;

  localparam int IDX_W  = 9;
  localparam int GEN_W  = 32;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int GEN_BITS_DEF   = 32;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_UPDATE  = 2'd1,
    FN_RESOLVE = 2'd2,
    FN_FREE    = 2'd3
  } ghm_func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_HANDLE = 2'd1,
    STAT_FULL       = 2'd2
  } ghm_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ghm_state_t;

  typedef struct packed {
    logic val;
    logic gen;
    logic nxt;
  } ghm_wen_t;

endpackage
`default_nettype wire

FILE: rtl/ghm_slot_store.sv
`default_nettype none
module ghm_slot_store #(
  parameter int SLOT_COUNT = ghm_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = ghm_pkg::GEN_BITS_DEF,
  localparam int ADDR_W    = $clog2(SLOT_COUNT),
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [ADDR_W-1:0]         rd_addr,
  output logic [ghm_pkg::VAL_W-1:0]      rd_val,
  output logic [GEN_BITS-1:0]            rd_gen,
  output logic [CNT_W-1:0]               rd_nxt,
  input  wire ghm_pkg::ghm_wen_t         wen,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [ghm_pkg::VAL_W-1:0] wr_val,
  input  wire logic [GEN_BITS-1:0]       wr_gen,
  input  wire logic [CNT_W-1:0]          wr_nxt
);

  logic [ghm_pkg::VAL_W-1:0] val_mem [SLOT_COUNT];
  logic [GEN_BITS-1:0]       gen_mem [SLOT_COUNT];
  logic [CNT_W-1:0]          nxt_mem [SLOT_COUNT];

  logic [ghm_pkg::VAL_W-1:0] rd_val_r;
  logic [GEN_BITS-1:0]       rd_gen_r;
  logic [CNT_W-1:0]          rd_nxt_r;

  always_ff @(posedge clk) begin
    if (wen.val) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (wen.gen) begin
      gen_mem[wr_addr] <= wr_gen;
    end
    if (wen.nxt) begin
      nxt_mem[wr_addr] <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val_r <= val_mem[rd_addr];
      rd_gen_r <= gen_mem[rd_addr];
      rd_nxt_r <= nxt_mem[rd_addr];
    end
  end

  assign rd_val = rd_val_r;
  assign rd_gen = rd_gen_r;
  assign rd_nxt = rd_nxt_r;

endmodule
`default_nettype wire

FILE: rtl/ghm_seq.sv
`default_nettype none
module ghm_seq #(
  parameter int SLOT_COUNT = ghm_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = ghm_pkg::GEN_BITS_DEF,
  localparam int ADDR_W    = $clog2(SLOT_COUNT),
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_func,
  input  wire logic [ghm_pkg::IDX_W-1:0]  in_handle_index,
  input  wire logic [ghm_pkg::GEN_W-1:0]  in_handle_generation,
  input  wire logic [ghm_pkg::VAL_W-1:0]  in_pointer_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ghm_pkg::STAT_W-1:0]      out_status,
  output logic [ghm_pkg::IDX_W-1:0]       out_index,
  output logic [ghm_pkg::GEN_W-1:0]       out_generation,
  output logic [ghm_pkg::VAL_W-1:0]       out_value,
  output logic                            rd_en,
  output logic [ADDR_W-1:0]               rd_addr,
  input  wire logic [ghm_pkg::VAL_W-1:0]  rd_val,
  input  wire logic [GEN_BITS-1:0]        rd_gen,
  input  wire logic [CNT_W-1:0]           rd_nxt,
  output ghm_pkg::ghm_wen_t               wen,
  output logic [ADDR_W-1:0]               wr_addr,
  output logic [ghm_pkg::VAL_W-1:0]       wr_val,
  output logic [GEN_BITS-1:0]             wr_gen,
  output logic [CNT_W-1:0]                wr_nxt
);

  localparam int IW    = ghm_pkg::IDX_W;
  localparam int GW    = ghm_pkg::GEN_W;
  localparam int CMP_W = (CNT_W > IW) ? CNT_W : IW;

  ghm_pkg::ghm_state_t state_r, state_nxt;
  ghm_pkg::ghm_func_t  func_r;
  logic [IW-1:0]                 idx_r;
  logic [GW-1:0]                 hgen_r;
  logic [ghm_pkg::VAL_W-1:0]     pval_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              head_r, head_nxt;

  logic                          out_valid_r, out_valid_nxt;
  ghm_pkg::ghm_status_t          status_r, status_nxt;
  logic [IW-1:0]                 oidx_r, oidx_nxt;
  logic [GW-1:0]                 ogen_r, ogen_nxt;
  logic [ghm_pkg::VAL_W-1:0]     oval_r, oval_nxt;

  logic accept;
  logic go;
  logic head_ok;
  logic handle_ok;
  ghm_pkg::ghm_wen_t wen_raw;

  assign in_stall = (state_r != ghm_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign head_ok  = (head_r != '0) && (head_r <= count_r);

  assign rd_en   = accept;
  assign rd_addr = (ghm_pkg::ghm_func_t'(in_func) == ghm_pkg::FN_ALLOC) ?
                   ADDR_W'(head_r - CNT_W'(1)) :
                   ADDR_W'(in_handle_index - IW'(1));

  assign handle_ok = (idx_r != '0) && (CMP_W'(idx_r) <= CMP_W'(count_r)) &&
                     (GW'(rd_gen) == hgen_r);

  assign go = (state_r == ghm_pkg::ST_EXEC) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    status_nxt = ghm_pkg::STAT_OK;
    oidx_nxt   = '0;
    ogen_nxt   = '0;
    oval_nxt   = '0;
    wen_raw    = '0;
    wr_addr    = ADDR_W'(idx_r - IW'(1));
    wr_val     = pval_r;
    wr_gen     = '0;
    wr_nxt     = '0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (func_r)
      ghm_pkg::FN_ALLOC: begin
        if (head_ok) begin
          wr_addr     = ADDR_W'(head_r - CNT_W'(1));
          wen_raw.val = 1'b1;
          oidx_nxt    = IW'(head_r);
          ogen_nxt    = GW'(rd_gen);
          head_nxt    = rd_nxt;
        end else if (count_r < CNT_W'(SLOT_COUNT)) begin
          wr_addr   = ADDR_W'(count_r);
          wen_raw   = '{val: 1'b1, gen: 1'b1, nxt: 1'b1};
          count_nxt = count_r + CNT_W'(1);
          oidx_nxt  = IW'(count_r + CNT_W'(1));
        end else begin
          status_nxt = ghm_pkg::STAT_FULL;
        end
      end
      ghm_pkg::FN_UPDATE: begin
        if (handle_ok) begin
          wen_raw.val = 1'b1;
        end else begin
          status_nxt = ghm_pkg::STAT_BAD_HANDLE;
        end
      end
      ghm_pkg::FN_RESOLVE: begin
        if (handle_ok) begin
          oval_nxt = rd_val;
        end else begin
          status_nxt = ghm_pkg::STAT_BAD_HANDLE;
        end
      end
      ghm_pkg::FN_FREE: begin
        if (handle_ok) begin
          wen_raw  = '{val: 1'b1, gen: 1'b1, nxt: 1'b1};
          wr_val   = '0;
          wr_gen   = rd_gen + GEN_BITS'(1);
          wr_nxt   = head_r;
          head_nxt = CNT_W'(idx_r);
        end else begin
          status_nxt = ghm_pkg::STAT_BAD_HANDLE;
        end
      end
      default: begin
        status_nxt = ghm_pkg::STAT_BAD_HANDLE;
      end
    endcase

    unique case (state_r)
      ghm_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ghm_pkg::ST_EXEC;
        end
      end
      ghm_pkg::ST_EXEC: begin
        if (go) begin
          state_nxt     = ghm_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ghm_pkg::ST_IDLE;
      end
    endcase

    if (!go) begin
      count_nxt = count_r;
      head_nxt  = head_r;
      wen_raw   = '0;
    end
  end

  assign wen = wen_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ghm_pkg::ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= ghm_pkg::ghm_func_t'(in_func);
      idx_r  <= in_handle_index;
      hgen_r <= in_handle_generation;
      pval_r <= in_pointer_value;
    end
    if (go) begin
      status_r <= status_nxt;
      oidx_r   <= oidx_nxt;
      ogen_r   <= ogen_nxt;
      oval_r   <= oval_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_index      = oidx_r;
  assign out_generation = ogen_r;
  assign out_value      = oval_r;

endmodule
`default_nettype wire

FILE: rtl/generational_handle_map.sv
// Generational handle map: a slot table that hands out handles made of a
// 1-based index and a generation count, with a free list for reuse.
// Requests arrive on the in_ channel (valid/stall); each request gives
// exactly one result on the out_ channel (valid/stall). A transfer happens
// at a rising edge with valid high and stall low.
// Functions: allocate, update the stored value, resolve, and free.
// In the transfer cycle of a request the slot is read from the table
// memory, and in the execute state that follows the handle is checked,
// the slot written back and the result registered. A new request is
// stalled until the current one has left its execute state, and a
// result is visible on out_valid after its execute state ends. The slot
// memory has one registered read port and one write port.
// The result sits in an output register, so a new request is taken while
// an earlier result still waits; if the receiver keeps stalling, the
// following request is held in its execute cycle until the result has gone.
// Reset (rst_n low, synchronous) empties the table and the free list and
// drops any pending result; no clearing pass over the memory is needed.
`default_nettype none
module generational_handle_map #(
  parameter int SLOT_COUNT = ghm_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = ghm_pkg::GEN_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_func,
  input  wire logic [ghm_pkg::IDX_W-1:0]  in_handle_index,
  input  wire logic [ghm_pkg::GEN_W-1:0]  in_handle_generation,
  input  wire logic [ghm_pkg::VAL_W-1:0]  in_pointer_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ghm_pkg::STAT_W-1:0]      out_status,
  output logic [ghm_pkg::IDX_W-1:0]       out_index,
  output logic [ghm_pkg::GEN_W-1:0]       out_generation,
  output logic [ghm_pkg::VAL_W-1:0]       out_value
);

  localparam int ADDR_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ghm_pkg::VAL_W-1:0] rd_val;
  logic [GEN_BITS-1:0]       rd_gen;
  logic [CNT_W-1:0]          rd_nxt;
  ghm_pkg::ghm_wen_t         wen;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ghm_pkg::VAL_W-1:0] wr_val;
  logic [GEN_BITS-1:0]       wr_gen;
  logic [CNT_W-1:0]          wr_nxt;

  ghm_seq #(
    .SLOT_COUNT(SLOT_COUNT),
    .GEN_BITS  (GEN_BITS)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_handle_index     (in_handle_index),
    .in_handle_generation(in_handle_generation),
    .in_pointer_value    (in_pointer_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_index           (out_index),
    .out_generation      (out_generation),
    .out_value           (out_value),
    .rd_en               (rd_en),
    .rd_addr             (rd_addr),
    .rd_val              (rd_val),
    .rd_gen              (rd_gen),
    .rd_nxt              (rd_nxt),
    .wen                 (wen),
    .wr_addr             (wr_addr),
    .wr_val              (wr_val),
    .wr_gen              (wr_gen),
    .wr_nxt              (wr_nxt)
  );

  ghm_slot_store #(
    .SLOT_COUNT(SLOT_COUNT),
    .GEN_BITS  (GEN_BITS)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_val (rd_val),
    .rd_gen (rd_gen),
    .rd_nxt (rd_nxt),
    .wen    (wen),
    .wr_addr(wr_addr),
    .wr_val (wr_val),
    .wr_gen (wr_gen),
    .wr_nxt (wr_nxt)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Request channel not stalled after a transfer.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("Result missing two cycles after a request transfer.");

  a_no_write_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> wen == '0)
    else $error("Slot memory written outside the execute cycle.");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ghm_pkg::STAT_OK) |->
      (out_index == '0) && (out_generation == '0) && (out_value == '0))
    else $error("Failed request returned non-zero result fields.");

endmodule
`default_nettype wire

FILE: test/ghm_checker.sv
module ghm_checker
  import ghm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [IDX_W-1:0]   in_handle_index,
  input  logic [GEN_W-1:0]   in_handle_generation,
  input  logic [VAL_W-1:0]   in_pointer_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [STAT_W-1:0]  out_status,
  input  logic [IDX_W-1:0]   out_index,
  input  logic [GEN_W-1:0]   out_generation,
  input  logic [VAL_W-1:0]   out_value,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 allocs_seen,
  output int                 bad_seen,
  output int                 full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SLOT_COUNT_DEF;

  typedef struct packed {
    ghm_status_t       status;
    logic [IDX_W-1:0]  index;
    logic [GEN_W-1:0]  generation;
    logic [VAL_W-1:0]  value;
  } answer_t;

  logic [VAL_W-1:0] slot_value [SLOTS];
  logic [GEN_W-1:0] slot_gen   [SLOTS];
  logic [IDX_W-1:0] slot_link  [SLOTS];
  logic [IDX_W-1:0] fill_level = '0;
  logic [IDX_W-1:0] free_head  = '0;

  answer_t pending_answers [$];
  int mismatch_count = 0;
  int outstanding    = 0;
  int answer_count   = 0;
  int alloc_count    = 0;
  int bad_count      = 0;
  int full_count     = 0;

  assign mismatches  = mismatch_count;
  assign pending     = outstanding;
  assign checked     = answer_count;
  assign allocs_seen = alloc_count;
  assign bad_seen    = bad_count;
  assign full_seen   = full_count;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    answer_t ans;
    logic [IDX_W-1:0] p;
    logic hit;
    if (!rst_n) begin
      fill_level = '0;
      free_head = '0;
      pending_answers.delete();
    end else begin
      if (in_valid && !in_stall) begin
        ans = '{STAT_OK, '0, '0, '0};
        if (ghm_func_t'(in_func) == FN_ALLOC) begin
          if (free_head != 0 && free_head <= fill_level) begin
            p = free_head - 1'b1;
            ans.index = free_head;
            ans.generation = slot_gen[p];
            free_head = slot_link[p];
            slot_value[p] = in_pointer_value;
          end else if (fill_level < SLOTS) begin
            p = fill_level;
            slot_value[p] = in_pointer_value;
            slot_gen[p] = '0;
            slot_link[p] = '0;
            fill_level = fill_level + 1'b1;
            ans.index = fill_level;
          end else begin
            ans.status = STAT_FULL;
          end
        end else begin
          hit = in_handle_index != 0 && in_handle_index <= fill_level &&
                slot_gen[in_handle_index - 1'b1] == in_handle_generation;
          p = in_handle_index - 1'b1;
          if (!hit) begin
            ans.status = STAT_BAD_HANDLE;
          end else begin
            case (ghm_func_t'(in_func))
              FN_UPDATE: slot_value[p] = in_pointer_value;
              FN_RESOLVE: ans.value = slot_value[p];
              default: begin
                slot_gen[p] = slot_gen[p] + 1'b1;
                slot_link[p] = free_head;
                slot_value[p] = '0;
                free_head = in_handle_index;
              end
            endcase
          end
        end
        pending_answers.push_back(ans);
      end
      if (out_valid && !out_stall) begin
        answer_count++;
        if (out_status == STAT_OK && out_index != 0) alloc_count++;
        if (out_status == STAT_BAD_HANDLE) bad_count++;
        if (out_status == STAT_FULL) full_count++;
        if (pending_answers.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          ans = pending_answers.pop_front();
          if (out_status !== ans.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, ans.status));
          if (out_index !== ans.index)
            report_mismatch($sformatf("index %0d, expected %0d", out_index, ans.index));
          if (out_generation !== ans.generation)
            report_mismatch($sformatf("generation %0h, expected %0h",
                                      out_generation, ans.generation));
          if (out_value !== ans.value)
            report_mismatch($sformatf("value %0h, expected %0h", out_value, ans.value));
        end
      end
    end
    outstanding <= pending_answers.size();
  end

endmodule

FILE: test/generational_handle_map_tb.sv
module generational_handle_map_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ghm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } handle_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FN_ALLOC;
  logic [IDX_W-1:0]   in_handle_index = '0;
  logic [GEN_W-1:0]   in_handle_generation = '0;
  logic [VAL_W-1:0]   in_pointer_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [IDX_W-1:0]   out_index;
  logic [GEN_W-1:0]   out_generation;
  logic [VAL_W-1:0]   out_value;

  int mismatches, pending, checked, allocs_seen, bad_seen, full_seen;
  int requests_sent = 0;
  int results_taken = 0;
  int stall_left = 0;
  handle_t live_handles [$];
  handle_t retired_handles [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  generational_handle_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_handle_index(in_handle_index), .in_handle_generation(in_handle_generation),
    .in_pointer_value(in_pointer_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_index(out_index), .out_generation(out_generation), .out_value(out_value)
  );

  ghm_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_handle_index(in_handle_index), .in_handle_generation(in_handle_generation),
    .in_pointer_value(in_pointer_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_index(out_index), .out_generation(out_generation), .out_value(out_value),
    .mismatches(mismatches), .pending(pending), .checked(checked),
    .allocs_seen(allocs_seen), .bad_seen(bad_seen), .full_seen(full_seen)
  );

  function automatic int draw_wait(bit quiet);
    if (quiet || $urandom_range(1) == 0) return 0;
    return $urandom_range(15);
  endfunction

  // Successful allocations are collected so that later requests can use real handles.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
      if (out_status == STAT_OK && out_index != 0)
        live_handles.push_back('{out_index, out_generation});
      stall_left = draw_wait((results_taken / 40) % 3 == 0);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      if (out_valid) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(ghm_func_t func, logic [IDX_W-1:0] idx,
                              logic [GEN_W-1:0] gen, logic [VAL_W-1:0] value);
    int gap;
    gap = draw_wait((requests_sent / 40) % 3 == 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_handle_index <= idx;
    in_handle_generation <= gen;
    in_pointer_value <= value;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_requests(int count, int alloc_pct, int free_pct);
    int roll;
    int k;
    ghm_func_t func;
    handle_t h;
    bit noise;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      h.idx = IDX_W'($urandom);
      h.gen = $urandom;
      if (roll < alloc_pct) begin
        func = FN_ALLOC;
      end else begin
        if (roll < alloc_pct + free_pct) func = FN_FREE;
        else func = $urandom_range(1) ? FN_UPDATE : FN_RESOLVE;
        noise = live_handles.size() == 0 || $urandom_range(99) < 12;
        if (!noise) begin
          k = $urandom_range(live_handles.size() - 1);
          h = live_handles[k];
          if (func == FN_FREE) begin
            live_handles.delete(k);
            retired_handles.push_back(h);
            if (retired_handles.size() > 64) void'(retired_handles.pop_front());
          end
        end else begin
          case ($urandom_range(3))
            0: h.idx = '0;
            1: ;
            2: if (retired_handles.size() != 0)
                 h = retired_handles[$urandom_range(retired_handles.size() - 1)];
            default: if (live_handles.size() != 0) begin
              h = live_handles[$urandom_range(live_handles.size() - 1)];
              h.gen[$urandom_range(GEN_W - 1)] ^= 1'b1;
            end
          endcase
        end
      end
      send_request(func, h.idx, h.gen, {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(FN_RESOLVE, '0, '0, '0);
    send_request(FN_UPDATE, 9'd1, '0, '1);
    send_request(FN_FREE, '1, '1, '0);
    send_request(FN_ALLOC, '1, '1, '0);
    send_request(FN_ALLOC, '0, '0, '1);
    send_request(FN_RESOLVE, 9'd1, '0, '1);
    send_request(FN_RESOLVE, 9'd2, '0, '0);
    send_request(FN_UPDATE, 9'd1, '0, 64'hA5A5_5A5A_C3C3_3C3C);
    send_request(FN_RESOLVE, 9'd1, '0, '0);
    send_request(FN_RESOLVE, 9'd1, 32'd1, '0);
    send_request(FN_UPDATE, 9'd1, 32'h8000_0000, '0);
    send_request(FN_RESOLVE, 9'd3, '0, '0);
    send_request(FN_FREE, 9'd1, '0, '1);
    send_request(FN_RESOLVE, 9'd1, '0, '0);
    send_request(FN_FREE, 9'd1, '0, '0);
    send_request(FN_FREE, 9'd2, '0, '0);
    send_request(FN_ALLOC, '0, '0, 64'd1);
    send_request(FN_ALLOC, '0, '0, 64'd2);
    send_request(FN_ALLOC, '0, '0, 64'd3);
    send_request(FN_RESOLVE, 9'd2, 32'd1, '0);
    send_request(FN_RESOLVE, 9'd1, 32'd1, '0);
    send_request(FN_UPDATE, 9'd3, '0, 64'h8000_0000_0000_0000);
    send_request(FN_RESOLVE, 9'd3, '0, '0);
    send_request(FN_FREE, '0, '0, '0);
    drain();

    random_requests(320, 90, 0);
    drain();
    random_requests(280, 5, 65);
    drain();
    random_requests(200, 40, 35);
    random_requests(250, 85, 5);
    drain();

    repeat (20) @(posedge clk);
    $display("Covered %0d requests: directed handle cases, filling to capacity, draining,",
             requests_sent);
    $display("mixed traffic and refilling; %0d results, %0d allocations, %0d bad, %0d full.",
             checked, allocs_seen, bad_seen, full_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
